/* rtl/core/ssca_pkg.sv */
// ----------------------------------------------------------------------------
// ssca_pkg
// Shared types and constants of the span and size-class allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ssca_pkg;

	// Region geometry
	localparam int SPAN_CNT    = 64;
	localparam int CLASS_CNT   = 129;
	localparam int LINK_DEPTH  = 262144;

	localparam logic [6:0]  SPAN_NIL      = 7'd64;
	localparam logic [22:0] OBJ_NIL       = 23'h400000;
	localparam logic [6:0]  REGION_RESET  = 7'd64;
	localparam logic [5:0]  RESV_RESET    = 6'd1;

	// Span tag kinds
	localparam logic [2:0] KIND_SMALL      = 3'd1;
	localparam logic [2:0] KIND_LARGE_HEAD = 3'd2;
	localparam logic [2:0] KIND_LARGE_TAIL = 3'd3;
	localparam logic [2:0] KIND_FREE_HEAD  = 3'd4;
	localparam logic [2:0] KIND_FREE_TAIL  = 3'd5;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOSPACE   = 2'd1;
	localparam logic [1:0] ST_ALIGN     = 2'd2;
	localparam logic [1:0] ST_FREE_IGN  = 2'd3;

	// Configuration register indexes (paddr[2])
	localparam logic REG_REGION = 1'b0;
	localparam logic REG_RESV   = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE,
		S_SM_HRD, S_SM_HCHK, S_SM_POP, S_SM_CARVE,
		S_L_CHK, S_L_RD, S_L_SPLIT, S_L_MARK, S_L_BUMP,
		S_F_RD, S_F_TAG, S_F_DIV, S_F_DCHK, S_F_SPUSH,
		S_F_NX, S_F_NXT, S_F_NXADD, S_F_PV, S_F_PVT, S_F_PVADD, S_F_FREE,
		S_RMRD, S_RMWR, S_MK_T, S_MK_H, S_PU1, S_PU2, S_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_DECODE,
		OP_SM_HRD, OP_SM_HCHK, OP_SM_POP, OP_SM_CARVE,
		OP_L_CHK, OP_L_RD, OP_L_SPLIT, OP_L_MARK, OP_L_BUMP,
		OP_F_RD, OP_F_TAG, OP_F_DIV, OP_F_DCHK, OP_F_SPUSH,
		OP_F_NX, OP_F_NXT, OP_F_NXADD, OP_F_PV, OP_F_PVT, OP_F_PVADD, OP_F_FREE,
		OP_RMRD, OP_RMWR, OP_MK_T, OP_MK_H, OP_PU1, OP_PU2, OP_DONE
	} dp_op_t;

	typedef struct packed {
		logic   load;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic is_free;
		logic align_bad;
		logic is_small;
		logic head_nil;
		logic bump1_fail;
		logic carve_more;
		logic walk_ok;
		logic fit;
		logic split;
		logic bump_fail;
		logic f_small_ok;
		logic f_lhead;
		logic div_last;
		logic obj_ok;
		logic nx_ok;
		logic nx_fh;
		logic s_nz;
		logic pv_ok;
		logic mk_free;
		logic out_room;
	} dp_stat_t;

	typedef struct packed {
		logic [6:0] region;
		logic [5:0] resv;
		logic       resv_wr;
	} cfg_t;

endpackage

`default_nettype wire

/* rtl/core/ssca_regs.sv */
// ----------------------------------------------------------------------------
// ssca_regs
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module ssca_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output ssca_pkg::cfg_t    cfg
);
	import ssca_pkg::*;

	logic [6:0] region_q;
	logic [5:0] resv_q;
	logic       wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= REGION_RESET;
			resv_q   <= RESV_RESET;
		end else if (wr) begin
			if (paddr[2] == REG_REGION) region_q <= pwdata[6:0];
			else resv_q <= pwdata[5:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_REGION) prdata = {25'd0, region_q};
		else prdata = {26'd0, resv_q};
	end

	// Writing the reserved count also reloads the bump pointer.
	assign cfg.region  = region_q;
	assign cfg.resv    = pwdata[5:0];
	assign cfg.resv_wr = wr && (paddr[2] == REG_RESV);

endmodule

`default_nettype wire

/* rtl/core/ssca_ctrl.sv */
// ----------------------------------------------------------------------------
// ssca_ctrl
// Sequencer for the allocator: walks each request through its datapath steps.
// ----------------------------------------------------------------------------
`default_nettype none

module ssca_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire ssca_pkg::dp_stat_t  st,
	output ssca_pkg::dp_cmd_t        cmd
);
	import ssca_pkg::*;

	state_t state_q, state_d, ret_q, ret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_DONE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	// Next state; the shared list and tag sub-sequences return through ret_q.
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		unique case (state_q)
			S_IDLE:      if (in_valid) state_d = S_DECODE;
			S_DECODE: begin
				if (st.is_free) state_d = S_F_RD;
				else if (st.align_bad) state_d = S_DONE;
				else if (st.is_small) state_d = S_SM_HRD;
				else state_d = S_L_CHK;
			end
			S_SM_HRD:    state_d = S_SM_HCHK;
			S_SM_HCHK: begin
				if (!st.head_nil) state_d = S_SM_POP;
				else if (st.bump1_fail) state_d = S_DONE;
				else state_d = S_SM_CARVE;
			end
			S_SM_POP:    state_d = S_DONE;
			S_SM_CARVE:  if (!st.carve_more) state_d = S_DONE;
			S_L_CHK:     state_d = st.walk_ok ? S_L_RD : S_L_BUMP;
			S_L_RD: begin
				if (st.fit) begin
					state_d = S_RMRD;
					ret_d   = S_L_SPLIT;
				end else state_d = S_L_CHK;
			end
			S_L_SPLIT: begin
				if (st.split) begin
					state_d = S_MK_T;
					ret_d   = S_L_MARK;
				end else state_d = S_L_MARK;
			end
			S_L_MARK: begin
				state_d = S_MK_T;
				ret_d   = S_DONE;
			end
			S_L_BUMP:    state_d = st.bump_fail ? S_DONE : S_L_MARK;
			S_F_RD:      state_d = S_F_TAG;
			S_F_TAG: begin
				if (st.f_small_ok) state_d = S_F_DIV;
				else if (st.f_lhead) state_d = S_F_NX;
				else state_d = S_DONE;
			end
			S_F_DIV:     if (st.div_last) state_d = S_F_DCHK;
			S_F_DCHK:    state_d = st.obj_ok ? S_F_SPUSH : S_DONE;
			S_F_SPUSH:   state_d = S_DONE;
			S_F_NX:      state_d = st.nx_ok ? S_F_NXT : S_F_PV;
			S_F_NXT: begin
				if (st.nx_fh) begin
					state_d = S_RMRD;
					ret_d   = S_F_NXADD;
				end else state_d = S_F_PV;
			end
			S_F_NXADD:   state_d = S_F_PV;
			S_F_PV:      state_d = st.s_nz ? S_F_PVT : S_F_FREE;
			S_F_PVT: begin
				if (st.pv_ok) begin
					state_d = S_RMRD;
					ret_d   = S_F_PVADD;
				end else state_d = S_F_FREE;
			end
			S_F_PVADD:   state_d = S_F_FREE;
			S_F_FREE: begin
				state_d = S_MK_T;
				ret_d   = S_DONE;
			end
			S_RMRD:      state_d = S_RMWR;
			S_RMWR:      state_d = ret_q;
			S_MK_T:      state_d = S_MK_H;
			S_MK_H:      state_d = st.mk_free ? S_PU1 : ret_q;
			S_PU1:       state_d = S_PU2;
			S_PU2:       state_d = ret_q;
			S_DONE:      if (st.out_room) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_stall = (state_q != S_IDLE);
		cmd.load = (state_q == S_IDLE) && in_valid;
		unique case (state_q)
			S_IDLE:     cmd.op = OP_NONE;
			S_DECODE:   cmd.op = OP_DECODE;
			S_SM_HRD:   cmd.op = OP_SM_HRD;
			S_SM_HCHK:  cmd.op = OP_SM_HCHK;
			S_SM_POP:   cmd.op = OP_SM_POP;
			S_SM_CARVE: cmd.op = OP_SM_CARVE;
			S_L_CHK:    cmd.op = OP_L_CHK;
			S_L_RD:     cmd.op = OP_L_RD;
			S_L_SPLIT:  cmd.op = OP_L_SPLIT;
			S_L_MARK:   cmd.op = OP_L_MARK;
			S_L_BUMP:   cmd.op = OP_L_BUMP;
			S_F_RD:     cmd.op = OP_F_RD;
			S_F_TAG:    cmd.op = OP_F_TAG;
			S_F_DIV:    cmd.op = OP_F_DIV;
			S_F_DCHK:   cmd.op = OP_F_DCHK;
			S_F_SPUSH:  cmd.op = OP_F_SPUSH;
			S_F_NX:     cmd.op = OP_F_NX;
			S_F_NXT:    cmd.op = OP_F_NXT;
			S_F_NXADD:  cmd.op = OP_F_NXADD;
			S_F_PV:     cmd.op = OP_F_PV;
			S_F_PVT:    cmd.op = OP_F_PVT;
			S_F_PVADD:  cmd.op = OP_F_PVADD;
			S_F_FREE:   cmd.op = OP_F_FREE;
			S_RMRD:     cmd.op = OP_RMRD;
			S_RMWR:     cmd.op = OP_RMWR;
			S_MK_T:     cmd.op = OP_MK_T;
			S_MK_H:     cmd.op = OP_MK_H;
			S_PU1:      cmd.op = OP_PU1;
			S_PU2:      cmd.op = OP_PU2;
			S_DONE:     cmd.op = OP_DONE;
			default:    cmd.op = OP_NONE;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/ssca_dp.sv */
// ----------------------------------------------------------------------------
// ssca_dp
// Allocator datapath: span tags, large free list links, class heads, object
// links, working registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssca_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ssca_pkg::dp_cmd_t  cmd,
	output ssca_pkg::dp_stat_t      st,
	input  wire ssca_pkg::cfg_t     cfg,
	input  wire logic [1:0]         req_type,
	input  wire logic [22:0]        req_size,
	input  wire logic [22:0]        req_alignment,
	input  wire logic [21:0]        free_address,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [21:0]             block_address,
	output logic [1:0]              status
);
	import ssca_pkg::*;

	// Stores
	logic [10:0] tag_mem [SPAN_CNT];
	logic [SPAN_CNT-1:0] tag_vld_q;
	logic [6:0]  prev_mem [SPAN_CNT];
	logic [6:0]  next_mem [SPAN_CNT];
	logic [22:0] chead_mem [CLASS_CNT];
	logic [CLASS_CNT-1:0] chead_vld_q;
	logic [22:0] link_mem [LINK_DEPTH];

	// Read data
	logic [10:0] tag_rdm_q;
	logic        tag_rdv_q;
	logic [10:0] tag_rd;
	logic [6:0]  prev_rd_q, next_rd_q;
	logic [22:0] chead_rdm_q;
	logic        chead_rdv_q;
	logic [22:0] chead_rd;
	logic [22:0] link_rd_q;

	// Memory controls
	logic        tag_we;
	logic [5:0]  tag_wa, tag_ra;
	logic [10:0] tag_wd;
	logic        prev_we, next_we;
	logic [5:0]  prev_wa, next_wa, ln_ra;
	logic [6:0]  prev_wd, next_wd;
	logic        chead_we;
	logic [7:0]  chead_wa, chead_ra;
	logic [22:0] chead_wd;
	logic        link_we;
	logic [17:0] link_wa, link_ra;
	logic [22:0] link_wd;

	// Request and working registers
	logic [1:0]  type_q;
	logic [22:0] size_q, align_q;
	logic [21:0] fa_q;
	logic [7:0]  klass_q, spans_q, have_q;
	logic [11:0] obj_q, rem_q;
	logic [16:0] off_q;
	logic [22:0] chead_q;
	logic [6:0]  b_q, steps_q, s_q, node_q, more_q, mk_s_q, mk_n_q, bump_q, lhead_q;
	logic        mk_free_q;
	logic [3:0]  dcnt_q;
	logic [21:0] addr_q;
	logic [1:0]  status_q;
	logic        out_vld_q;
	logic [21:0] out_addr_q;
	logic [1:0]  out_status_q;

	// Derived values
	logic        is_align, align_bad;
	logic [22:0] size_eff;
	logic [23:0] kl_sum, sp_sum;
	logic [7:0]  klass_c, spans_c;
	logic [6:0]  limit;
	logic [2:0]  tkind;
	logic [7:0]  tcnt;
	logic [8:0]  nx_c;
	logic [6:0]  sm1;
	logic [7:0]  more_c;
	logic [7:0]  mk_end;
	logic [12:0] div_t;
	logic [11:0] rem_next;
	logic        publish;

	assign tag_rd   = tag_rdv_q ? tag_rdm_q : 11'd0;
	assign chead_rd = chead_rdv_q ? chead_rdm_q : OBJ_NIL;
	assign tkind    = tag_rd[10:8];
	assign tcnt     = tag_rd[7:0];

	always_comb begin
		is_align  = (type_q == 2'd1) && (align_q > 23'd16);
		align_bad = is_align && (align_q > 23'd65536);
		if (is_align) size_eff = (size_q <= 23'd2048) ? 23'd2049 : size_q;
		else size_eff = (size_q == 23'd0) ? 23'd1 : size_q;
		kl_sum   = {1'b0, size_eff} + 24'd15;
		sp_sum   = {1'b0, size_eff} + 24'd65535;
		klass_c  = kl_sum[11:4];
		spans_c  = sp_sum[23:16];
		limit    = (cfg.region > 7'd64) ? 7'd64 : cfg.region;
		nx_c     = {2'd0, s_q} + {1'b0, spans_q};
		sm1      = s_q - 7'd1;
		mk_end   = {1'b0, mk_s_q} + {1'b0, mk_n_q} - 8'd1;
		div_t    = {rem_q, fa_q[4'd15 - dcnt_q]};
		rem_next = (div_t >= {1'b0, obj_q}) ? 12'(div_t - {1'b0, obj_q}) : div_t[11:0];
		if (tkind == KIND_FREE_TAIL) more_c = tcnt;
		else if (tkind == KIND_FREE_HEAD && tcnt == 8'd1) more_c = 8'd1;
		else more_c = 8'd0;
	end

	// Status towards the sequencer
	always_comb begin
		st.is_free    = type_q[1];
		st.align_bad  = align_bad;
		st.is_small   = !is_align && (size_eff <= 23'd2048);
		st.head_nil   = chead_rd[22];
		st.bump1_fail = ({1'b0, bump_q} + 8'd1) > {1'b0, limit};
		st.carve_more = ({1'b0, off_q} + {6'd0, obj_q}) <= 18'd65536;
		st.walk_ok    = !steps_q[6] && !b_q[6];
		st.fit        = tcnt >= spans_q;
		st.split      = have_q > spans_q;
		st.bump_fail  = ({2'd0, bump_q} + {1'b0, spans_q}) > {2'd0, limit};
		st.f_small_ok = (tkind == KIND_SMALL) && (tcnt != 8'd0) && (tcnt < 8'd129);
		st.f_lhead    = (tkind == KIND_LARGE_HEAD) && (fa_q[15:0] == 16'd0);
		st.div_last   = (dcnt_q == 4'd15);
		st.obj_ok     = (rem_q == 12'd0) &&
			(({1'b0, fa_q[15:0]} + {5'd0, obj_q}) <= 17'd65536);
		st.nx_ok      = (nx_c < {2'd0, bump_q}) && (nx_c < 9'd64);
		st.nx_fh      = (tkind == KIND_FREE_HEAD);
		st.s_nz       = (s_q != 7'd0);
		st.pv_ok      = (more_c != 8'd0) && (more_c <= {1'b0, s_q});
		st.mk_free    = mk_free_q;
		st.out_room   = !out_vld_q || !out_stall;
	end

	assign publish = (cmd.op == OP_DONE) && st.out_room;

	// Memory port selection
	always_comb begin
		tag_we   = 1'b0; tag_wa = 6'd0; tag_wd = 11'd0; tag_ra = b_q[5:0];
		prev_we  = 1'b0; prev_wa = 6'd0; prev_wd = SPAN_NIL;
		next_we  = 1'b0; next_wa = 6'd0; next_wd = SPAN_NIL;
		ln_ra    = b_q[5:0];
		chead_we = 1'b0; chead_wa = klass_q; chead_wd = chead_q; chead_ra = klass_q;
		link_we  = 1'b0; link_wa = {s_q[5:0], off_q[15:4]}; link_wd = chead_q;
		link_ra  = chead_rd[21:4];
		unique case (cmd.op)
			OP_SM_HCHK: begin
				if (st.head_nil && !st.bump1_fail) begin
					tag_we = 1'b1;
					tag_wa = bump_q[5:0];
					tag_wd = {KIND_SMALL, klass_q};
				end
			end
			OP_SM_POP: begin
				chead_we = 1'b1;
				chead_wd = link_rd_q;
			end
			OP_SM_CARVE: begin
				if (st.carve_more) link_we = 1'b1;
				else chead_we = 1'b1;
			end
			OP_F_RD:    tag_ra = fa_q[21:16];
			OP_F_SPUSH: begin
				link_we  = 1'b1;
				link_wa  = fa_q[21:4];
				link_wd  = chead_rd;
				chead_we = 1'b1;
				chead_wd = {1'b0, fa_q};
			end
			OP_F_NX:    tag_ra = nx_c[5:0];
			OP_F_PV:    tag_ra = sm1[5:0];
			OP_RMRD:    ln_ra = node_q[5:0];
			OP_RMWR: begin
				if (!prev_rd_q[6]) begin
					next_we = 1'b1;
					next_wa = prev_rd_q[5:0];
					next_wd = next_rd_q;
				end
				if (!next_rd_q[6]) begin
					prev_we = 1'b1;
					prev_wa = next_rd_q[5:0];
					prev_wd = prev_rd_q;
				end
			end
			OP_MK_T: begin
				if (mk_n_q > 7'd1 && mk_end < 8'd64) begin
					tag_we = 1'b1;
					tag_wa = mk_end[5:0];
					tag_wd = {mk_free_q ? KIND_FREE_TAIL : KIND_LARGE_TAIL, 1'b0, mk_n_q};
				end
			end
			OP_MK_H: begin
				if (!mk_s_q[6]) begin
					tag_we = 1'b1;
					tag_wa = mk_s_q[5:0];
					tag_wd = {mk_free_q ? KIND_FREE_HEAD : KIND_LARGE_HEAD, 1'b0, mk_n_q};
				end
			end
			OP_PU1: begin
				if (!node_q[6]) begin
					prev_we = 1'b1;
					prev_wa = node_q[5:0];
					prev_wd = SPAN_NIL;
					next_we = 1'b1;
					next_wa = node_q[5:0];
					next_wd = lhead_q;
				end
			end
			OP_PU2: begin
				if (!node_q[6] && !lhead_q[6]) begin
					prev_we = 1'b1;
					prev_wa = lhead_q[5:0];
					prev_wd = node_q;
				end
			end
			default: ;
		endcase
	end

	// Memories
	always_ff @(posedge clk) begin
		if (tag_we) tag_mem[tag_wa] <= tag_wd;
		tag_rdm_q <= tag_mem[tag_ra];
		tag_rdv_q <= tag_vld_q[tag_ra];
	end

	always_ff @(posedge clk) begin
		if (prev_we) prev_mem[prev_wa] <= prev_wd;
		if (next_we) next_mem[next_wa] <= next_wd;
		prev_rd_q <= prev_mem[ln_ra];
		next_rd_q <= next_mem[ln_ra];
	end

	always_ff @(posedge clk) begin
		if (chead_we) chead_mem[chead_wa] <= chead_wd;
		chead_rdm_q <= chead_mem[chead_ra];
		chead_rdv_q <= chead_vld_q[chead_ra];
	end

	always_ff @(posedge clk) begin
		if (link_we) link_mem[link_wa] <= link_wd;
		link_rd_q <= link_mem[link_ra];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bump_q      <= {1'b0, RESV_RESET};
			lhead_q     <= SPAN_NIL;
			out_vld_q   <= 1'b0;
			tag_vld_q   <= '0;
			chead_vld_q <= '0;
		end else begin
			if (cfg.resv_wr) bump_q <= {1'b0, cfg.resv};
			else if (cmd.op == OP_SM_HCHK && st.head_nil && !st.bump1_fail)
				bump_q <= bump_q + 7'd1;
			else if (cmd.op == OP_L_BUMP && !st.bump_fail)
				bump_q <= bump_q + spans_q[6:0];
			if (cmd.op == OP_RMWR && prev_rd_q[6]) lhead_q <= next_rd_q;
			else if (cmd.op == OP_PU2 && !node_q[6]) lhead_q <= node_q;
			if (tag_we) tag_vld_q[tag_wa] <= 1'b1;
			if (chead_we) chead_vld_q[chead_wa] <= 1'b1;
			if (publish) out_vld_q <= 1'b1;
			else if (!out_stall) out_vld_q <= 1'b0;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q  <= req_type;
			size_q  <= req_size;
			align_q <= req_alignment;
			fa_q    <= free_address;
		end
		if (publish) begin
			out_addr_q   <= addr_q;
			out_status_q <= status_q;
		end
		unique case (cmd.op)
			OP_DECODE: begin
				klass_q  <= klass_c;
				spans_q  <= spans_c;
				b_q      <= lhead_q;
				steps_q  <= 7'd0;
				addr_q   <= 22'd0;
				status_q <= align_bad ? ST_ALIGN : ST_OK;
			end
			OP_SM_HCHK: begin
				if (!st.head_nil) addr_q <= chead_rd[21:0];
				else if (st.bump1_fail) status_q <= ST_NOSPACE;
				else begin
					s_q     <= bump_q;
					obj_q   <= {klass_q, 4'd0};
					off_q   <= {5'd0, klass_q, 4'd0};
					chead_q <= OBJ_NIL;
				end
			end
			OP_SM_CARVE: begin
				if (st.carve_more) begin
					chead_q <= {1'b0, s_q[5:0], off_q[15:0]};
					off_q   <= off_q + {5'd0, obj_q};
				end else addr_q <= {s_q[5:0], 16'd0};
			end
			OP_L_RD: begin
				if (st.fit) begin
					have_q <= tcnt;
					node_q <= b_q;
				end else begin
					b_q     <= next_rd_q;
					steps_q <= steps_q + 7'd1;
				end
			end
			OP_L_SPLIT: begin
				if (st.split) begin
					mk_s_q    <= b_q + spans_q[6:0];
					mk_n_q    <= have_q[6:0] - spans_q[6:0];
					mk_free_q <= 1'b1;
					node_q    <= b_q + spans_q[6:0];
				end
			end
			OP_L_MARK: begin
				mk_s_q    <= b_q;
				mk_n_q    <= spans_q[6:0];
				mk_free_q <= 1'b0;
				addr_q    <= {b_q[5:0], 16'd0};
			end
			OP_L_BUMP: begin
				if (st.bump_fail) status_q <= ST_NOSPACE;
				else b_q <= bump_q;
			end
			OP_F_TAG: begin
				if (st.f_small_ok) begin
					obj_q   <= {tcnt, 4'd0};
					klass_q <= tcnt;
					rem_q   <= 12'd0;
					dcnt_q  <= 4'd0;
				end else if (st.f_lhead) begin
					s_q     <= {1'b0, fa_q[21:16]};
					spans_q <= tcnt;
				end else status_q <= ST_FREE_IGN;
			end
			OP_F_DIV: begin
				rem_q  <= rem_next;
				dcnt_q <= dcnt_q + 4'd1;
			end
			OP_F_DCHK: if (!st.obj_ok) status_q <= ST_FREE_IGN;
			OP_F_NXT: begin
				if (st.nx_fh) begin
					node_q <= nx_c[6:0];
					more_q <= tcnt[6:0];
				end
			end
			OP_F_NXADD: spans_q <= spans_q + {1'b0, more_q};
			OP_F_PVT: begin
				if (st.pv_ok) begin
					node_q <= s_q - more_c[6:0];
					more_q <= more_c[6:0];
				end
			end
			OP_F_PVADD: begin
				s_q     <= s_q - more_q;
				spans_q <= spans_q + {1'b0, more_q};
			end
			OP_F_FREE: begin
				mk_s_q    <= s_q;
				mk_n_q    <= spans_q[6:0];
				mk_free_q <= 1'b1;
				node_q    <= s_q;
			end
			default: ;
		endcase
	end

	assign out_valid     = out_vld_q;
	assign block_address = out_addr_q;
	assign status        = out_status_q;

endmodule

`default_nettype wire

/* rtl/core/span_size_class_allocator_top.sv */
// ----------------------------------------------------------------------------
// span_size_class_allocator_top
// Segregated-fit allocator over a region of 64 KiB spans.
// ----------------------------------------------------------------------------
// Each request on the input channel (in_valid / in_stall) is an allocate, an
// aligned allocate or a free, and produces exactly one result on the output
// channel (out_valid / out_stall): a byte offset and a status.
// The block handles one request at a time; in_stall is high from the cycle
// after acceptance until the result has been moved into the output register.
// The work depends on the path: a small allocate served from its class list
// pops the head object; a small allocate that carves a fresh span links all
// further objects of the span, the most for the 16-byte class, since the
// object links are written one per cycle into a store with one write port.
// A large allocate inspects at most 64 free-list entries, besides decoding,
// unlinking, splitting and tagging.
// A small free runs a 16-step remainder unit that checks the object
// boundary; a large free may merge with free neighbours on either side.
// The result register lets a new request be accepted while the previous
// result still waits; if the receiver stalls, the next result waits in the
// sequencer until the register is free.
// Reset empties every class list and the large free list, clears the span
// tags (per-entry valid bits) and sets the bump pointer to the reserved count.
// Users write configuration on the APB-style port only while idle; unenforced.
// ----------------------------------------------------------------------------
`default_nettype none

module span_size_class_allocator_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [1:0]   req_type,
	input  wire logic [22:0]  req_size,
	input  wire logic [22:0]  req_alignment,
	input  wire logic [21:0]  free_address,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [21:0]       block_address,
	output logic [1:0]        status,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import ssca_pkg::*;

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t st;

	// Configuration registers; a reserved-count write also reloads the bump
	// pointer inside the datapath.
	ssca_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The sequencer owns the input handshake and steps the datapath.
	ssca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// The datapath holds all stores and the output register.
	ssca_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.cfg           (cfg),
		.req_type      (req_type),
		.req_size      (req_size),
		.req_alignment (req_alignment),
		.free_address  (free_address),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.block_address (block_address),
		.status        (status)
	);

endmodule

`default_nettype wire

/* rtl/core/ssca_checker.sv */
// ----------------------------------------------------------------------------
// ssca_props
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ssca_props (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [21:0] block_address,
	input wire logic [1:0]  status
);
	import ssca_pkg::*;

	// A result held by the receiver stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// Failed or ignored requests never carry an address.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> block_address == 22'd0)
		else $error("non-zero address on failed request");

	// Every granted block starts on a grain boundary.
	a_grain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> block_address[3:0] == 4'd0)
		else $error("address off grain boundary");

	// An accepted request keeps the block busy in the following cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted without going busy");

endmodule

bind span_size_class_allocator_top ssca_props u_ssca_props (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.block_address (block_address),
	.status        (status)
);

`default_nettype wire

/* verif/ssca_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ssca_checker
// Watches the request, result and register ports of the span allocator, keeps
// its own copy of the allocator state, and compares every result it sees.
// ----------------------------------------------------------------------------
`default_nettype none

module ssca_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [22:0] req_size,
	input  wire logic [22:0] req_alignment,
	input  wire logic [21:0] free_address,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [21:0] block_address,
	input  wire logic [1:0]  status,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	output int               fail_count,
	output int               pending
);
	import ssca_pkg::*;

	localparam logic [1:0] REQ_ALIGNED = 2'd1;
	localparam int SPAN_SZ = 65536;
	localparam int GRAIN   = 16;
	localparam int SMALL_MAX = 2048;
	localparam int NO_OBJ  = -1;

	typedef struct packed {
		logic [21:0] addr;
		logic [1:0]  st;
	} grant_t;

	int unsigned region_cnt, bump;
	int unsigned free_head;
	int unsigned tag_kind[SPAN_CNT];
	int unsigned tag_count[SPAN_CNT];
	int unsigned prev_span[SPAN_CNT];
	int unsigned next_span[SPAN_CNT];
	int          class_top[CLASS_CNT];
	int          obj_next[LINK_DEPTH];
	grant_t      grants_due[$];

	assign pending = grants_due.size();

	function automatic void set_tag(int unsigned s, int unsigned k, int unsigned c);
		if (s < SPAN_CNT) begin
			tag_kind[s] = k;
			tag_count[s] = c;
		end
	endfunction

	function automatic void unlink_span(int unsigned b);
		int unsigned p, n;
		if (b >= SPAN_CNT)
			return;
		p = prev_span[b];
		n = next_span[b];
		if (p < SPAN_CNT)
			next_span[p] = n;
		else
			free_head = n;
		if (n < SPAN_CNT)
			prev_span[n] = p;
	endfunction

	function automatic void link_span(int unsigned b);
		if (b >= SPAN_CNT)
			return;
		prev_span[b] = SPAN_NIL;
		next_span[b] = free_head;
		if (free_head < SPAN_CNT)
			prev_span[free_head] = b;
		free_head = b;
	endfunction

	function automatic void tag_free(int unsigned s, int unsigned n);
		if (n > 1)
			set_tag(s + n - 1, KIND_FREE_TAIL, n);
		set_tag(s, KIND_FREE_HEAD, n);
		link_span(s);
	endfunction

	function automatic void tag_used(int unsigned s, int unsigned n);
		if (n > 1)
			set_tag(s + n - 1, KIND_LARGE_TAIL, n);
		set_tag(s, KIND_LARGE_HEAD, n);
	endfunction

	function automatic bit take_fresh(int unsigned n, output int unsigned first);
		int unsigned lim;
		lim = (region_cnt < SPAN_CNT) ? region_cnt : SPAN_CNT;
		first = 0;
		if (bump + n > lim)
			return 0;
		first = bump;
		bump += n;
		return 1;
	endfunction

	function automatic bit grab_spans(int unsigned size, output int unsigned addr);
		int unsigned want, b, have, first;
		want = (size + SPAN_SZ - 1) / SPAN_SZ;
		b = free_head;
		addr = 0;
		// First fit along the free span list, splitting off what is left over.
		for (int steps = 0; steps < SPAN_CNT && b < SPAN_CNT; steps++) begin
			have = tag_count[b];
			if (have >= want) begin
				unlink_span(b);
				if (have > want)
					tag_free(b + want, have - want);
				tag_used(b, want);
				addr = b * SPAN_SZ;
				return 1;
			end
			b = next_span[b];
		end
		if (!take_fresh(want, first))
			return 0;
		tag_used(first, want);
		addr = first * SPAN_SZ;
		return 1;
	endfunction

	function automatic bit grab_object(int unsigned k, output int unsigned addr);
		int unsigned s, obj, n, a;
		addr = 0;
		if (class_top[k] != NO_OBJ) begin
			addr = class_top[k];
			class_top[k] = obj_next[addr / GRAIN];
			return 1;
		end
		if (!take_fresh(1, s))
			return 0;
		set_tag(s, KIND_SMALL, k);
		obj = k * GRAIN;
		n = SPAN_SZ / obj;
		for (int unsigned i = 1; i < n; i++) begin
			a = s * SPAN_SZ + i * obj;
			obj_next[a / GRAIN] = class_top[k];
			class_top[k] = a;
		end
		addr = s * SPAN_SZ;
		return 1;
	endfunction

	function automatic void release_spans(int unsigned s, int unsigned n);
		int unsigned nx, pk, pc, more;
		nx = s + n;
		// Merge with a free block that follows, then with one that precedes.
		if (nx < bump && nx < SPAN_CNT && tag_kind[nx] == KIND_FREE_HEAD) begin
			more = tag_count[nx];
			unlink_span(nx);
			n += more;
		end
		if (s > 0) begin
			pk = tag_kind[s - 1];
			pc = tag_count[s - 1];
			more = 0;
			if (pk == KIND_FREE_TAIL)
				more = pc;
			else if (pk == KIND_FREE_HEAD && pc == 1)
				more = 1;
			if (more != 0 && more <= s) begin
				unlink_span(s - more);
				s -= more;
				n += more;
			end
		end
		tag_free(s, n);
	endfunction

	function automatic logic [1:0] give_back(int unsigned fa);
		int unsigned idx, off, k, c, obj;
		idx = fa / SPAN_SZ;
		off = fa % SPAN_SZ;
		if (idx >= SPAN_CNT)
			return ST_FREE_IGN;
		k = tag_kind[idx];
		c = tag_count[idx];
		if (k == KIND_SMALL) begin
			if (c == 0 || c >= CLASS_CNT)
				return ST_FREE_IGN;
			obj = c * GRAIN;
			if (off % obj != 0 || off / obj >= SPAN_SZ / obj)
				return ST_FREE_IGN;
			obj_next[fa / GRAIN] = class_top[c];
			class_top[c] = fa;
			return ST_OK;
		end
		if (k == KIND_LARGE_HEAD && off == 0) begin
			release_spans(idx, c);
			return ST_OK;
		end
		return ST_FREE_IGN;
	endfunction

	function automatic grant_t serve_request(logic [1:0] t, int unsigned size,
			int unsigned align, int unsigned fa);
		grant_t g;
		int unsigned addr;
		bit ok;
		addr = 0;
		if (t[1]) begin
			g.st = give_back(fa);
		end else if (t == REQ_ALIGNED && align > GRAIN) begin
			if (align > SPAN_SZ) begin
				g.st = ST_ALIGN;
			end else begin
				// A small request that asks for real alignment takes a whole span.
				if (size <= SMALL_MAX)
					size = SMALL_MAX + 1;
				ok = grab_spans(size, addr);
				g.st = ok ? ST_OK : ST_NOSPACE;
			end
		end else begin
			if (size == 0)
				size = 1;
			if (size <= SMALL_MAX)
				ok = grab_object((size + GRAIN - 1) / GRAIN, addr);
			else
				ok = grab_spans(size, addr);
			g.st = ok ? ST_OK : ST_NOSPACE;
		end
		g.addr = (g.st == ST_OK) ? addr[21:0] : '0;
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			region_cnt = REGION_RESET;
			bump = RESV_RESET;
			free_head = SPAN_NIL;
			for (int i = 0; i < SPAN_CNT; i++) begin
				tag_kind[i] = 0;
				tag_count[i] = 0;
			end
			for (int i = 0; i < CLASS_CNT; i++)
				class_top[i] = NO_OBJ;
			grants_due.delete();
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_RESV) begin
					bump = pwdata[5:0];
				end else begin
					region_cnt = pwdata[6:0];
				end
			end
			// Results are checked before this edge's request is predicted.
			if (out_valid && !out_stall) begin
				if (grants_due.size() == 0) begin
					$error("result with no request outstanding: address %0h status %0d",
						block_address, status);
					fail_count++;
				end else begin
					want = grants_due.pop_front();
					if (block_address !== want.addr) begin
						$error("block_address: expected %0h, got %0h", want.addr,
							block_address);
						fail_count++;
					end
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				grants_due.push_back(serve_request(req_type, req_size, req_alignment,
					free_address));
		end
	end

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives allocate, aligned allocate and free requests into the span allocator
// across several region settings and judges the run from the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import ssca_pkg::*;

	localparam logic [1:0] REQ_ALLOC   = 2'd0;
	localparam logic [1:0] REQ_ALIGNED = 2'd1;
	localparam logic [1:0] REQ_FREE    = 2'd2;
	localparam logic [1:0] REQ_FREE_B1 = 2'd3;
	localparam int SPAN_SZ   = 65536;
	localparam int IDLE_MAX  = 30000;
	localparam int PHASE_REQ = 100;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  req_type;
	logic [22:0] req_size;
	logic [22:0] req_alignment;
	logic [21:0] free_address;
	logic        out_valid;
	logic        out_stall;
	logic [21:0] block_address;
	logic [1:0]  status;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int pending;
	int idle_cycles;
	// Gap and stall shaping: off for quiet stretches, hold_off for a long stall.
	bit gaps_on;
	bit hold_off;
	// Granted addresses, reused as the targets of later frees.
	logic [21:0] granted[$];

	span_size_class_allocator_top DUT (.*);

	ssca_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .req_size(req_size),
		.req_alignment(req_alignment), .free_address(free_address),
		.out_valid(out_valid), .out_stall(out_stall),
		.block_address(block_address), .status(status),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The watchdog counts cycles in which neither channel moves a request or a
	// result; the longest correct pause is a 16-byte class carve.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_MAX) begin
			$display("== FAIL ==");
			$finish;
		end
		// Every granted non-zero address is kept as a candidate for a later free.
		if (out_valid && !out_stall && status == ST_OK && block_address != '0)
			granted.push_back(block_address);
	end

	// Receiver: runs of stall and of flow, most of them short, a few long.
	initial begin
		int run;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
				hold_off = 1'b0;
			end else if (!gaps_on) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 2) == 0);
				run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
					: $urandom_range(0, 3);
				repeat (run) @(negedge clk);
			end
		end
	end

	task automatic send_request(logic [1:0] t, int unsigned size, int unsigned align,
			int unsigned fa);
		int gap;
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 2) == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		req_type      <= t;
		req_size      <= size[22:0];
		req_alignment <= align[22:0];
		free_address  <= fa[21:0];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic go_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	function automatic int unsigned pick_alignment();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return $urandom_range(0, 16);
		if (r < 8)
			return 1 << $urandom_range(5, 16);
		if (r < 9)
			return $urandom_range(17, SPAN_SZ);
		return $urandom_range(SPAN_SZ + 1, 4194304);
	endfunction

	function automatic int unsigned pick_large_size();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(2049, 4194304);
		return ($urandom_range(1, 4) - 1) * SPAN_SZ + $urandom_range(1, SPAN_SZ);
	endfunction

	// One random request: mostly well-formed allocate and free traffic, with
	// some frees of stray or interior addresses mixed in.
	task automatic random_request();
		int r, k;
		int unsigned fa;
		r = $urandom_range(0, 99);
		fa = $urandom_range(0, 4194303);
		if (r < 30) begin
			send_request(REQ_ALLOC, $urandom_range(0, 2048), pick_alignment(), fa);
		end else if (r < 45) begin
			send_request(REQ_ALLOC, pick_large_size(), pick_alignment(), fa);
		end else if (r < 55) begin
			send_request(REQ_ALIGNED, ($urandom_range(0, 1) == 0) ?
				$urandom_range(0, 2048) : pick_large_size(), pick_alignment(), fa);
		end else if (r < 88 && granted.size() != 0) begin
			k = $urandom_range(0, granted.size() - 1);
			fa = granted[k];
			if ($urandom_range(0, 4) != 0)
				granted.delete(k);
			if ($urandom_range(0, 9) == 0)
				fa = fa + 8 * $urandom_range(1, 8);
			send_request(($urandom_range(0, 3) == 0) ? REQ_FREE_B1 : REQ_FREE,
				$urandom_range(0, 4194304), pick_alignment(), fa);
		end else begin
			send_request(($urandom_range(0, 1) == 0) ? REQ_FREE_B1 : REQ_FREE,
				$urandom_range(0, 4194304), pick_alignment(), fa);
		end
	endtask

	initial begin
		logic [21:0] big, obj;
		int unsigned region_set[6] = '{64, 12, 1, 64, 5, 64};
		int unsigned resv_set[6]   = '{0, 3, 0, 63, 9, 2};
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		req_type      = REQ_ALLOC;
		req_size      = '0;
		req_alignment = '0;
		free_address  = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		gaps_on       = 1'b0;
		hold_off      = 1'b0;
		idle_cycles   = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		write_reg(REG_REGION, 32'd64);
		write_reg(REG_RESV, 32'd1);

		// Directed part: size extremes, each alignment case and odd frees.
		send_request(REQ_ALLOC, 0, 0, 0);
		send_request(REQ_ALLOC, 1, 0, 0);
		send_request(REQ_ALLOC, 2048, 0, 0);
		send_request(REQ_ALLOC, 2049, 0, 0);
		send_request(REQ_ALLOC, 4194304, 0, 0);
		send_request(REQ_ALIGNED, 100, 0, 0);
		send_request(REQ_ALIGNED, 100, 16, 0);
		send_request(REQ_ALIGNED, 1, 17, 0);
		send_request(REQ_ALIGNED, 70000, 65536, 0);
		send_request(REQ_ALIGNED, 16, 65537, 0);
		send_request(REQ_ALIGNED, 16, 4194304, 0);
		send_request(REQ_ALLOC, 3 * SPAN_SZ, 0, 0);
		go_quiet();
		big = granted[$];
		obj = granted[0];
		send_request(REQ_FREE, 0, 0, big + SPAN_SZ);
		send_request(REQ_FREE, 0, 0, big + 32);
		send_request(REQ_FREE_B1, 0, 0, big);
		send_request(REQ_FREE, 0, 0, big);
		send_request(REQ_FREE, 0, 0, obj + 8);
		send_request(REQ_FREE, 0, 0, obj);
		send_request(REQ_FREE, 0, 0, obj);
		send_request(REQ_FREE, 0, 0, 0);
		send_request(REQ_FREE, 0, 0, 4194303);
		send_request(REQ_FREE, 0, 0, 60 * SPAN_SZ);
		go_quiet();

		// Random part over several register settings, the extremes among them.
		for (int ph = 0; ph <= 6; ph++) begin
			if (ph > 0) begin
				write_reg(REG_REGION, region_set[ph - 1]);
				write_reg(REG_RESV, resv_set[ph - 1]);
			end
			for (int i = 0; i < PHASE_REQ; i++) begin
				// A quiet stretch at the start of each phase, gaps after that.
				gaps_on = (i >= 10);
				if (ph == 1 && i == 40)
					hold_off = 1'b1;
				if (ph == 2 && i == 50)
					go_quiet();
				random_request();
			end
			go_quiet();
		end

		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

/* span_size_class_allocator_top.f */
rtl/core/ssca_pkg.sv
rtl/core/ssca_regs.sv
rtl/core/ssca_ctrl.sv
rtl/core/ssca_dp.sv
rtl/core/span_size_class_allocator_top.sv
rtl/core/ssca_checker.sv
verif/ssca_checker.sv
verif/testbench.sv
